### src/two_link_arm_inverse_kinematics_defines.svh
// Assertion macros shared by the two-link arm inverse kinematics RTL.
`ifndef TWO_LINK_ARM_INVERSE_KINEMATICS_DEFINES_SVH
`define TWO_LINK_ARM_INVERSE_KINEMATICS_DEFINES_SVH
`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define TLAIK_ASSERT_HOLD(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlaik assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define TLAIK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlaik assertion failed");
`else
`define TLAIK_ASSERT_HOLD(lbl, ante, cons)
`define TLAIK_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### src/tlaik_pkg.sv
// Types, status codes and constants of the two-link arm inverse kinematics block.
package tlaik_pkg;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OUTER = 2'd1;
  localparam logic [1:0] ST_INNER = 2'd2;

  // Width of the CORDIC x/y datapath, of angles in signed Q5.30, and of the x operands.
  localparam int CW = 40;
  localparam int ZW = 35;
  localparam int XW = 36;

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;

  typedef struct packed {
    logic [15:0]        target_depth;
    logic signed [15:0] lateral_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] shoulder_angle;
    logic [14:0]        elbow_angle;
    logic [13:0]        wrist_angle;
  } out_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 neg;
    logic [15:0]          depth;
    logic [15:0]          abs_offset;
    logic signed [XW-1:0] x_alpha;
    logic signed [XW-1:0] x_elbow;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
    case (i)
      0:  return 35'sd843314856;
      1:  return 35'sd497837829;
      2:  return 35'sd263043836;
      3:  return 35'sd133525158;
      4:  return 35'sd67021686;
      5:  return 35'sd33543515;
      6:  return 35'sd16775850;
      7:  return 35'sd8388437;
      8:  return 35'sd4194282;
      9:  return 35'sd2097149;
      10: return 35'sd1048575;
      11: return 35'sd524287;
      12: return 35'sd262143;
      13: return 35'sd131071;
      14: return 35'sd65535;
      15: return 35'sd32767;
      16: return 35'sd16383;
      17: return 35'sd8191;
      18: return 35'sd4095;
      19: return 35'sd2047;
      20: return 35'sd1023;
      21: return 35'sd511;
      22: return 35'sd255;
      23: return 35'sd127;
      24: return 35'sd63;
      25: return 35'sd31;
      26: return 35'sd15;
      27: return 35'sd8;
      28: return 35'sd4;
      29: return 35'sd2;
      30: return 35'sd1;
      default: return 35'sd0;
    endcase
  endfunction

endpackage

### src/two_link_arm_inverse_kinematics.sv
// Two-link planar arm inverse kinematics, top level.
// A target (depth, signed lateral offset, Q8.8) enters on the in_ channel by
// valid/ready; one result (status and three joint angles in radians) leaves
// on the out_ channel for every target, in order. Link lengths sit in two
// registers on the APB port: upper link at address 0, lower link at 4.
// The result passes 22 + CORDIC_ITERATIONS registers (38 with the default
// setting): four front stages, sixteen square root stages, one setup stage,
// one stage per CORDIC iteration and the output register.
// A new target can be taken every cycle unless a stalled receiver holds the
// pipeline; throughput is then one item per cycle.
// Reset clears all valid bits and sets both link lengths to 15.
// When the receiver stalls, the result waits in the output register and the
// pipeline keeps moving until a finished result reaches its last stage;
// the whole pipeline and in_ready then hold until the waiting one is taken.
// Unreachable targets give status 1 or 2 and all angles zero.
`include "two_link_arm_inverse_kinematics_defines.svh"
module two_link_arm_inverse_kinematics #(
  parameter int ANGLE_FRACTION_BITS = 13,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tlaik_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tlaik_pkg::out_item_t  out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int ZW = tlaik_pkg::ZW;
  localparam int SH = 30 - ANGLE_FRACTION_BITS;
  localparam logic signed [ZW-1:0] RND = ZW'(64'sd1 <<< (SH - 1));

  // Configuration registers
  logic [6:0] upper_r, lower_r;
  logic       cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {25'b0, lower_r} : {25'b0, upper_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= 7'd15;
      lower_r <= 7'd15;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        lower_r <= pwdata[6:0];
      end else begin
        upper_r <= pwdata[6:0];
      end
    end
  end

  // Pipeline
  logic                 adv;
  logic                 fr_v, sq_v, cd_v;
  tlaik_pkg::side_t     fr_side, sq_side;
  logic [63:0]          fr_prod;
  logic [31:0]          sq_root;
  logic [1:0]           cd_status;
  logic                 cd_neg;
  logic signed [ZW-1:0] cd_phi, cd_alpha, cd_elbow;

  tlaik_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .v_i       (in_valid),
    .data_i    (in_data),
    .upper_len (upper_r),
    .lower_len (lower_r),
    .v_o       (fr_v),
    .side_o    (fr_side),
    .prod_o    (fr_prod)
  );

  tlaik_isqrt u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .v_i    (fr_v),
    .side_i (fr_side),
    .val_i  (fr_prod),
    .v_o    (sq_v),
    .side_o (sq_side),
    .root_o (sq_root)
  );

  tlaik_cordic #(
    .ITER (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .v_i      (sq_v),
    .side_i   (sq_side),
    .k_i      (sq_root),
    .v_o      (cd_v),
    .status_o (cd_status),
    .neg_o    (cd_neg),
    .phi_o    (cd_phi),
    .alpha_o  (cd_alpha),
    .elbow_o  (cd_elbow)
  );

  // Output register
  logic                 out_valid_r, out_valid_nxt, out_load;
  tlaik_pkg::out_item_t out_data_r, out_data_nxt;
  logic signed [ZW-1:0] shoulder_z, sh_q, el_q, ph_q;

  // The pipeline moves unless a finished result sits behind a waiting one.
  assign adv = !cd_v || !out_valid_r || out_ready;
  assign in_ready = adv;
  assign out_load = cd_v && (!out_valid_r || out_ready);

  always_comb begin
    shoulder_z = tlaik_pkg::HALF_PI_Q30 + (cd_neg ? -cd_phi : cd_phi) - cd_alpha;
    sh_q = (shoulder_z + RND) >>> SH;
    el_q = (cd_elbow + RND) >>> SH;
    ph_q = (cd_phi + RND) >>> SH;
    out_data_nxt.status = cd_status;
    if (cd_status == tlaik_pkg::ST_OK) begin
      out_data_nxt.shoulder_angle = sh_q[15:0];
      out_data_nxt.elbow_angle = el_q[14:0];
      out_data_nxt.wrist_angle = ph_q[13:0];
    end else begin
      out_data_nxt.shoulder_angle = '0;
      out_data_nxt.elbow_angle = '0;
      out_data_nxt.wrist_angle = '0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  logic out_unreach, out_angles_zero, out_status_known, cfg_wr_upper;

  assign out_unreach = out_valid && out_data.status != tlaik_pkg::ST_OK;
  assign out_angles_zero = out_data.shoulder_angle == '0 && out_data.elbow_angle == '0 &&
                           out_data.wrist_angle == '0;
  assign out_status_known = out_data.status == tlaik_pkg::ST_OK ||
                            out_data.status == tlaik_pkg::ST_OUTER ||
                            out_data.status == tlaik_pkg::ST_INNER;
  assign cfg_wr_upper = cfg_wr && !paddr[2];

  `TLAIK_ASSERT_HOLD(a_unreach_zero, out_unreach, out_angles_zero)
  `TLAIK_ASSERT_HOLD(a_status_code, out_valid, out_status_known)
  `TLAIK_ASSERT_HOLD(a_ready_when_empty, !out_valid, in_ready)
  `TLAIK_ASSERT_NEXT(a_cfg_upper, cfg_wr_upper, upper_r == $past(pwdata[6:0]))

endmodule

### src/tlaik_front.sv
// Front end: reachability screen, squares and the product under the square root.
module tlaik_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  v_i,
  input  tlaik_pkg::in_item_t   data_i,
  input  logic [6:0]            upper_len,
  input  logic [6:0]            lower_len,
  output logic                  v_o,
  output tlaik_pkg::side_t      side_o,
  output logic [63:0]           prod_o
);

  // Stage 1
  logic        v1_r;
  logic [15:0] d1_r, ax1_r, sum1_r, diff1_r;
  logic        neg1_r, outer1_r;
  logic [15:0] ax1_nxt, sum1_nxt, diff1_nxt;
  logic [7:0]  lsum;
  logic [6:0]  ldiff;
  logic        outer1_nxt;

  always_comb begin
    ax1_nxt = data_i.lateral_offset[15] ? (~data_i.lateral_offset + 16'd1)
                                        : data_i.lateral_offset;
    lsum = {1'b0, upper_len} + {1'b0, lower_len};
    ldiff = (upper_len > lower_len) ? (upper_len - lower_len) : (lower_len - upper_len);
    sum1_nxt = {lsum, 8'b0};
    diff1_nxt = {1'b0, ldiff, 8'b0};
    outer1_nxt = ({1'b0, data_i.target_depth} + {1'b0, ax1_nxt}) > {1'b0, sum1_nxt};
  end

  // Stage 2
  logic        v2_r;
  logic [15:0] d2_r, ax2_r;
  logic        neg2_r, outer2_r;
  logic [31:0] dd2_r, xx2_r, sum2_r, diff2_r;
  logic [13:0] aa2_r, bb2_r;

  // Stage 3
  logic                 v3_r;
  tlaik_pkg::side_t     side3_r, side3_nxt;
  logic [31:0]          f1_r, f2_r, f1_nxt, f2_nxt;
  logic [32:0]          c2;

  always_comb begin
    c2 = {1'b0, dd2_r} + {1'b0, xx2_r};
    side3_nxt.neg = neg2_r;
    side3_nxt.depth = d2_r;
    side3_nxt.abs_offset = ax2_r;
    if (outer2_r) begin
      side3_nxt.status = tlaik_pkg::ST_OUTER;
    end else if (c2 < {1'b0, diff2_r} || c2 == 33'd0 || upper_len == 7'd0 ||
                 lower_len == 7'd0) begin
      side3_nxt.status = tlaik_pkg::ST_INNER;
    end else begin
      side3_nxt.status = tlaik_pkg::ST_OK;
    end
    side3_nxt.x_alpha = $signed({3'b0, c2}) + $signed({6'b0, aa2_r, 16'b0})
                        - $signed({6'b0, bb2_r, 16'b0});
    side3_nxt.x_elbow = $signed({3'b0, c2}) - $signed({6'b0, aa2_r, 16'b0})
                        - $signed({6'b0, bb2_r, 16'b0});
    // Both factors are nonnegative and below 2^32 whenever the target is reachable.
    f1_nxt = sum2_r - c2[31:0];
    f2_nxt = c2[31:0] - diff2_r;
  end

  // Stage 4
  logic             v4_r;
  tlaik_pkg::side_t side4_r;
  logic [63:0]      prod4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r     <= data_i.target_depth;
      ax1_r    <= ax1_nxt;
      neg1_r   <= data_i.lateral_offset[15];
      outer1_r <= outer1_nxt;
      sum1_r   <= sum1_nxt;
      diff1_r  <= diff1_nxt;

      d2_r     <= d1_r;
      ax2_r    <= ax1_r;
      neg2_r   <= neg1_r;
      outer2_r <= outer1_r;
      dd2_r    <= d1_r * d1_r;
      xx2_r    <= ax1_r * ax1_r;
      sum2_r   <= sum1_r * sum1_r;
      diff2_r  <= diff1_r * diff1_r;
      aa2_r    <= upper_len * upper_len;
      bb2_r    <= lower_len * lower_len;

      side3_r  <= side3_nxt;
      f1_r     <= f1_nxt;
      f2_r     <= f2_nxt;

      side4_r  <= side3_r;
      prod4_r  <= f1_r * f2_r;
    end
  end

  assign v_o = v4_r;
  assign side_o = side4_r;
  assign prod_o = prod4_r;

endmodule

### src/tlaik_isqrt.sv
// Pipelined integer square root of a 64-bit value, two result bits per stage.
module tlaik_isqrt (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             v_i,
  input  tlaik_pkg::side_t side_i,
  input  logic [63:0]      val_i,
  output logic             v_o,
  output tlaik_pkg::side_t side_o,
  output logic [31:0]      root_o
);

  localparam int STEPS = 32;
  localparam int PER = 2;
  localparam int STAGES = STEPS / PER;

  logic             v_r    [STAGES];
  tlaik_pkg::side_t side_r [STAGES];
  logic [63:0]      rem_r  [STAGES];
  logic [63:0]      root_r [STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < STAGES; s++) begin
        v_r[s] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= v_i;
      for (int s = 1; s < STAGES; s++) begin
        v_r[s] <= v_r[s-1];
      end
    end
  end

  for (genvar s = 0; s < STAGES; s++) begin : g_st
    logic [63:0]      rem_in, root_in, rv, rr, bt, trial;
    tlaik_pkg::side_t side_in;

    if (s == 0) begin : g_first
      assign rem_in = val_i;
      assign root_in = 64'd0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign side_in = side_r[s-1];
    end

    // Restoring square root: one trial subtraction per result bit.
    always_comb begin
      rv = rem_in;
      rr = root_in;
      bt = 64'd0;
      trial = 64'd0;
      for (int j = 0; j < PER; j++) begin
        bt = 64'd1 << (62 - 2 * (PER * s + j));
        trial = rr + bt;
        if (rv >= trial) begin
          rv = rv - trial;
          rr = (rr >> 1) + bt;
        end else begin
          rr = rr >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rv;
        root_r[s] <= rr;
        side_r[s] <= side_in;
      end
    end
  end

  assign v_o = v_r[STAGES-1];
  assign side_o = side_r[STAGES-1];
  assign root_o = root_r[STAGES-1][31:0];

endmodule

### src/tlaik_cordic.sv
// Three-lane pipelined vectoring CORDIC giving phi, alpha and the elbow angle.
module tlaik_cordic #(
  parameter int ITER = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                v_i,
  input  tlaik_pkg::side_t                    side_i,
  input  logic [31:0]                         k_i,
  output logic                                v_o,
  output logic [1:0]                          status_o,
  output logic                                neg_o,
  output logic signed [tlaik_pkg::ZW-1:0]     phi_o,
  output logic signed [tlaik_pkg::ZW-1:0]     alpha_o,
  output logic signed [tlaik_pkg::ZW-1:0]     elbow_o
);

  localparam int CW = tlaik_pkg::CW;
  localparam int ZW = tlaik_pkg::ZW;
  localparam int LANES = 3;

  logic                 v_r   [ITER+1];
  logic [1:0]           st_r  [ITER+1];
  logic                 neg_r [ITER+1];
  logic signed [CW-1:0] x_r   [ITER+1][LANES];
  logic signed [CW-1:0] y_r   [ITER+1][LANES];
  logic signed [ZW-1:0] z_r   [ITER+1][LANES];
  logic                 zf_r  [ITER+1][LANES];

  logic signed [CW-1:0] x0 [LANES];
  logic signed [CW-1:0] y0 [LANES];
  logic signed [CW-1:0] ex [LANES];
  logic signed [CW-1:0] ey [LANES];
  logic signed [ZW-1:0] ez [LANES];
  logic                 ezf [LANES];

  // Lane 0: phi from (depth, |offset|); lanes 1 and 2 share the root as y.
  always_comb begin
    x0[0] = CW'($signed({1'b0, side_i.depth}));
    y0[0] = CW'($signed({1'b0, side_i.abs_offset}));
    x0[1] = CW'(side_i.x_alpha);
    y0[1] = CW'($signed({1'b0, k_i}));
    x0[2] = CW'(side_i.x_elbow);
    y0[2] = CW'($signed({1'b0, k_i}));
    for (int l = 0; l < LANES; l++) begin
      ezf[l] = (x0[l] == '0) && (y0[l] == '0);
      // A negative x is turned a quarter so the iterations start in range.
      if (x0[l] < 0) begin
        ex[l] = y0[l];
        ey[l] = -x0[l];
        ez[l] = tlaik_pkg::HALF_PI_Q30;
      end else begin
        ex[l] = x0[l];
        ey[l] = y0[l];
        ez[l] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= ITER; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= v_i;
      for (int i = 0; i < ITER; i++) begin
        v_r[i+1] <= v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]  <= side_i.status;
      neg_r[0] <= side_i.neg;
      for (int l = 0; l < LANES; l++) begin
        x_r[0][l]  <= ex[l];
        y_r[0][l]  <= ey[l];
        z_r[0][l]  <= ez[l];
        zf_r[0][l] <= ezf[l];
      end
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_it
    localparam logic signed [ZW-1:0] ATAN = tlaik_pkg::atan_q30(i);
    logic signed [CW-1:0] xn [LANES];
    logic signed [CW-1:0] yn [LANES];
    logic signed [ZW-1:0] zn [LANES];

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        if (y_r[i][l] > 0) begin
          xn[l] = x_r[i][l] + (y_r[i][l] >>> i);
          yn[l] = y_r[i][l] - (x_r[i][l] >>> i);
          zn[l] = z_r[i][l] + ATAN;
        end else begin
          xn[l] = x_r[i][l] - (y_r[i][l] >>> i);
          yn[l] = y_r[i][l] + (x_r[i][l] >>> i);
          zn[l] = z_r[i][l] - ATAN;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[i+1]  <= st_r[i];
        neg_r[i+1] <= neg_r[i];
        for (int l = 0; l < LANES; l++) begin
          x_r[i+1][l]  <= xn[l];
          y_r[i+1][l]  <= yn[l];
          z_r[i+1][l]  <= zn[l];
          zf_r[i+1][l] <= zf_r[i][l];
        end
      end
    end
  end

  assign v_o = v_r[ITER];
  assign status_o = st_r[ITER];
  assign neg_o = neg_r[ITER];
  assign phi_o = zf_r[ITER][0] ? '0 : z_r[ITER][0];
  assign alpha_o = zf_r[ITER][1] ? '0 : z_r[ITER][1];
  assign elbow_o = zf_r[ITER][2] ? '0 : z_r[ITER][2];

endmodule

### bench/two_link_arm_inverse_kinematics_test.sv
// Self-checking testbench for the two-link arm inverse kinematics block.
`timescale 1ns / 100ps

module two_link_arm_inverse_kinematics_test;

  localparam int ANGLE_BITS = 13;
  localparam int ITERS = 16;
  localparam int LATENCY = 22 + ITERS;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [2:0] ADDR_UPPER = 3'd0;
  localparam logic [2:0] ADDR_LOWER = 3'd4;
  localparam longint PI_HALF = 64'sd1686629713;

  // Predicts the joint angles from the current link lengths and keeps
  // the predictions in transfer order for comparison.
  class ik_scoreboard;
    tlaik_pkg::out_item_t pending_angles[$];
    int unsigned upper_len = 15;
    int unsigned lower_len = 15;
    int errors = 0;

    function longint asr(longint v, int s);
      return v >>> s;
    endfunction

    function longint isqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return longint'(r);
    endfunction

    function longint rotate_angle(longint y, longint x);
      longint z;
      longint t;
      longint xs;
      longint ys;
      z = 0;
      if (y == 0 && x == 0) return 0;
      if (x < 0) begin
        t = x;
        x = y;
        y = -t;
        z = PI_HALF;
      end
      for (int i = 0; i < ITERS; i++) begin
        xs = asr(x, i);
        ys = asr(y, i);
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + longint'(tlaik_pkg::atan_q30(i));
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - longint'(tlaik_pkg::atan_q30(i));
        end
      end
      return z;
    endfunction

    function longint to_radians(longint z);
      int sh;
      sh = 30 - ANGLE_BITS;
      return asr(z + (longint'(1) << (sh - 1)), sh);
    endfunction

    function void note_target(tlaik_pkg::in_item_t t);
      tlaik_pkg::out_item_t r;
      longint d, x, ax, a, b, c2, diff, sum, k, phi, alpha, elb, sh;
      r = '0;
      d = longint'(t.target_depth);
      x = longint'(t.lateral_offset);
      ax = x < 0 ? -x : x;
      a = upper_len;
      b = lower_len;
      diff = (a > b ? a - b : b - a) << 8;
      c2 = x * x + d * d;
      if (d + ax > ((a + b) << 8)) begin
        r.status = tlaik_pkg::ST_OUTER;
      end else if (c2 < diff * diff || c2 == 0 || a == 0 || b == 0) begin
        r.status = tlaik_pkg::ST_INNER;
      end else begin
        sum = (a + b) << 8;
        k = isqrt(longint'(sum * sum - c2) * longint'(c2 - diff * diff));
        phi = rotate_angle(ax, d);
        alpha = rotate_angle(k, c2 + ((a * a) << 16) - ((b * b) << 16));
        elb = rotate_angle(k, c2 - ((a * a) << 16) - ((b * b) << 16));
        sh = PI_HALF + (x >= 0 ? phi : -phi) - alpha;
        r.status = tlaik_pkg::ST_OK;
        r.shoulder_angle = 16'(to_radians(sh));
        r.elbow_angle = 15'(to_radians(elb));
        r.wrist_angle = 14'(to_radians(phi));
      end
      pending_angles.push_back(r);
    endfunction

    function void check_angles(tlaik_pkg::out_item_t got);
      tlaik_pkg::out_item_t exp;
      if (pending_angles.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending_angles.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
        errors++;
      end
      if (got.shoulder_angle !== exp.shoulder_angle) begin
        $display("%0t: shoulder expected %0d actual %0d", $time,
                 exp.shoulder_angle, got.shoulder_angle);
        errors++;
      end
      if (got.elbow_angle !== exp.elbow_angle) begin
        $display("%0t: elbow expected %0d actual %0d", $time,
                 exp.elbow_angle, got.elbow_angle);
        errors++;
      end
      if (got.wrist_angle !== exp.wrist_angle) begin
        $display("%0t: wrist expected %0d actual %0d", $time,
                 exp.wrist_angle, got.wrist_angle);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  tlaik_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  tlaik_pkg::out_item_t out_data;
  logic psel = 0;
  logic penable = 0;
  logic pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ik_scoreboard angle_board = new();
  int idle_cycles = 0;
  bit long_hold = 0;

  two_link_arm_inverse_kinematics DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Receiver: random stalls per result, plus one long hold-off on request.
  initial begin
    int gap;
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (long_hold) begin
        gap = 300;
        long_hold = 0;
      end
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) angle_board.check_angles(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("two_link_arm_inverse_kinematics test failed");
      $finish;
    end
  end

  task automatic send_target(input tlaik_pkg::in_item_t t, input bit use_gap);
    int gap;
    gap = use_gap ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18)) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    angle_board.note_target(t);
  endtask

  task automatic write_link(input logic [2:0] addr, input int unsigned len);
    in_valid <= 0;
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= addr;
    pwdata <= len;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (addr == ADDR_UPPER) angle_board.upper_len = len;
    else angle_board.lower_len = len;
  endtask

  // All results must be back before the link lengths change.
  task automatic wait_drained();
    in_valid <= 0;
    @(posedge clk);
    while (angle_board.pending_angles.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic tlaik_pkg::in_item_t pick_target();
    tlaik_pkg::in_item_t t;
    int unsigned reach;
    int sel;
    reach = (angle_board.upper_len + angle_board.lower_len) << 8;
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      // Mostly points whose depth and offset each lie within the reach, so the angles get exercised.
      t.target_depth = 16'($urandom_range(0, reach > 65535 ? 65535 : reach));
      t.lateral_offset = 16'($urandom_range(0, reach) - $urandom_range(0, reach));
    end else begin
      t.target_depth = 16'($urandom);
      t.lateral_offset = 16'($urandom);
    end
    return t;
  endfunction

  initial begin
    int unsigned lens[6][2] = '{'{15, 15}, '{1, 1}, '{127, 127}, '{1, 127},
                                 '{127, 1}, '{40, 23}};
    tlaik_pkg::in_item_t t;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: field extremes, zero reach, zero depth, zero offset, bounds.
    t = '{16'd0, 16'sd0};          send_target(t, 0);
    t = '{16'd0, 16'sd2560};       send_target(t, 0);
    t = '{16'd0, -16'sd2560};      send_target(t, 0);
    t = '{16'd2560, 16'sd0};       send_target(t, 0);
    t = '{16'd7680, 16'sd0};       send_target(t, 0);
    t = '{16'd7681, 16'sd0};       send_target(t, 0);
    t = '{16'd3840, 16'sd3840};    send_target(t, 0);
    t = '{16'd3840, -16'sd3841};   send_target(t, 0);
    t = '{16'd65535, 16'sd32767};  send_target(t, 0);
    t = '{16'd65535, -16'sd32768}; send_target(t, 0);
    t = '{16'd1, 16'sd1};          send_target(t, 0);
    t = '{16'd1000, -16'sd1};      send_target(t, 0);
    wait_drained();
    write_link(ADDR_UPPER, 20);
    write_link(ADDR_LOWER, 5);
    t = '{16'd3839, 16'sd0};       send_target(t, 0);
    t = '{16'd3840, 16'sd0};       send_target(t, 0);
    t = '{16'd0, -16'sd3840};      send_target(t, 0);
    t = '{16'd100, 16'sd100};      send_target(t, 0);

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_link(ADDR_UPPER, lens[p][0]);
      write_link(ADDR_LOWER, lens[p][1]);
      if (p == 2) long_hold = 1;
      for (int n = 0; n < 75; n++) begin
        t = pick_target();
        send_target(t, !(p == 2 || (n >= 30 && n < 45)));
      end
    end

    wait_drained();
    if (angle_board.errors == 0) begin
      $display("two_link_arm_inverse_kinematics test passed");
    end else begin
      $display("two_link_arm_inverse_kinematics test failed");
    end
    $finish;
  end

endmodule
